// File: design/ffha_pkg.sv
// Shared types, constants and helpers for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int UW = $clog2(HEAP_UNITS);     // unit index bits
    localparam int SW = UW + 1;                 // size / break bits

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [SW-1:0] LIMIT_RESET = SW'(HEAP_UNITS);

    typedef struct packed {
        logic          used;
        logic [SW-1:0] size;
    } t_hdr;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_F_CHK, S_F_EVAL, S_F_GROW, S_T_CUT, S_T_SPLIT, S_T_DONE,
        S_G_CHK, S_G_EVAL, S_G_FIN, S_R_WAIT, S_R_EVAL, S_R_NCHK, S_R_NXT, S_RESP
    } t_state;

    typedef enum logic [1:0] {W_HOLD, W_ZERO, W_U, W_STEP} t_wsel;
    typedef enum logic [2:0] {WR_NONE, WR_CAND, WR_SPLIT, WR_GROW, WR_GFIN} t_wr;

    typedef struct packed {
        logic  ld_req;
        t_wsel wsel;
        logic  tot_clr;
        logic  tot_add;
        logic  lat_find;
        logic  lat_orig;
        logic  lat_merge;
        t_wr   wr;
        logic  lat_result;
        logic  set_copy;
        logic  set_oom;
        logic  set_zero;
        logic  set_move;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic req_alloc;
        logic req_free;
        logic req_resize;
        logic loc_ok;
        logic bytes_zero;
        logic w_end;
        logic hdr_used;
        logic w_is_u;
        logic fit;
        logic grow_ok;
        logic split;
        logic orig_fits;
        logic next_fits;
        logic move;
        logic out_free;
    } t_sts;

    // payload offset of the chunk whose header sits at unit u, mod 64K
    function automatic logic [15:0] offset_of(input logic [UW-1:0] u);
        logic [UW-1:0] p;
        p = u + UW'(1);
        return {p, 4'b0000};
    endfunction

endpackage
`default_nettype wire

// File: design/ffha_ctrl.sv
// Sequencer for the allocator: walks, splits, growth, merge and response.
`default_nettype none
module ffha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire ffha_pkg::t_sts i_sts,
    output ffha_pkg::t_cmd     o_cmd,
    output ffha_pkg::t_state   o_state
);
    import ffha_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.ld_req = 1'b1;
                    n_state      = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.req_alloc) begin
                    o_cmd.wsel = W_ZERO;
                    n_state    = S_F_CHK;
                end else if (i_sts.req_free) begin
                    if (i_sts.loc_ok) begin
                        o_cmd.wsel    = W_U;
                        o_cmd.tot_clr = 1'b1;
                        n_state       = S_G_CHK;
                    end else begin
                        n_state = S_RESP;
                    end
                end else if (i_sts.req_resize && i_sts.loc_ok) begin
                    o_cmd.wsel = W_U;
                    if (i_sts.bytes_zero) begin
                        o_cmd.set_zero = 1'b1;
                        o_cmd.tot_clr  = 1'b1;
                        n_state        = S_G_CHK;
                    end else begin
                        n_state = S_R_WAIT;
                    end
                end else begin
                    n_state = S_RESP;
                end
            end
            S_F_CHK:  n_state = i_sts.w_end ? S_F_GROW : S_F_EVAL;
            S_F_EVAL: begin
                if (i_sts.fit) begin
                    o_cmd.lat_find = 1'b1;
                    n_state        = S_T_CUT;
                end else begin
                    o_cmd.wsel = W_STEP;
                    n_state    = S_F_CHK;
                end
            end
            S_F_GROW: begin
                if (i_sts.grow_ok) begin
                    o_cmd.wr = WR_GROW;
                    n_state  = S_T_DONE;
                end else begin
                    o_cmd.set_oom = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_T_CUT: begin
                o_cmd.wr = WR_CAND;
                n_state  = i_sts.split ? S_T_SPLIT : S_T_DONE;
            end
            S_T_SPLIT: begin
                o_cmd.wr = WR_SPLIT;
                n_state  = S_T_DONE;
            end
            S_T_DONE: begin
                o_cmd.lat_result = 1'b1;
                if (i_sts.move) begin
                    // moved: report copy, then release the old chunk
                    o_cmd.set_copy = 1'b1;
                    o_cmd.wsel     = W_U;
                    o_cmd.tot_clr  = 1'b1;
                    n_state        = S_G_CHK;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_G_CHK:  n_state = i_sts.w_end ? S_G_FIN : S_G_EVAL;
            S_G_EVAL: begin
                if (i_sts.hdr_used && !i_sts.w_is_u) begin
                    n_state = S_G_FIN;
                end else begin
                    o_cmd.tot_add = 1'b1;
                    o_cmd.wsel    = W_STEP;
                    n_state       = S_G_CHK;
                end
            end
            S_G_FIN: begin
                o_cmd.wr = WR_GFIN;
                n_state  = S_RESP;
            end
            S_R_WAIT: n_state = S_R_EVAL;
            S_R_EVAL: begin
                o_cmd.lat_orig = 1'b1;
                if (i_sts.orig_fits) begin
                    n_state = S_T_CUT;
                end else begin
                    o_cmd.wsel = W_STEP;
                    n_state    = S_R_NCHK;
                end
            end
            S_R_NCHK: begin
                if (i_sts.w_end) begin
                    o_cmd.set_move = 1'b1;
                    o_cmd.wsel     = W_ZERO;
                    n_state        = S_F_CHK;
                end else begin
                    n_state = S_R_NXT;
                end
            end
            S_R_NXT: begin
                if (i_sts.next_fits) begin
                    o_cmd.lat_merge = 1'b1;
                    n_state         = S_T_CUT;
                end else begin
                    o_cmd.set_move = 1'b1;
                    o_cmd.wsel     = W_ZERO;
                    n_state        = S_F_CHK;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

// File: design/ffha_dpath.sv
// Datapath: header memory, walk pointer, break, limit register, result register.
`default_nettype none
module ffha_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [39:0]    i_req_data,
    input  wire logic [12:0]    i_cfg_data,
    input  wire ffha_pkg::t_cmd i_cmd,
    output ffha_pkg::t_sts      o_sts,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output logic [55:0]         o_rsp_data,
    input  wire logic           i_cfg_wr,
    output logic [12:0]         o_limit
);
    import ffha_pkg::*;

    t_hdr          r_mem [HEAP_UNITS];
    t_hdr          r_rd;

    logic [1:0]    r_act;
    logic [15:0]   r_off;
    logic          r_bzero;
    logic [SW-1:0] r_csz, r_brk, r_limit, r_w, r_tot, r_raw, r_cs, r_orig;
    logic [UW-1:0] r_cand;
    logic          r_keep, r_merge, r_move;
    logic [1:0]    r_status;
    logic [15:0]   r_res, r_csrc, r_cbytes;
    logic          r_ovalid;
    logic [55:0]   r_odata;

    logic [16:0]   req_round;
    logic [UW-1:0] unit, u;
    logic [SW-1:0] room, s1, s, lim, cut_size, orig_m1;
    logic [SW:0]   cs_diff;
    logic          wr_en;
    logic [UW-1:0] wr_addr;
    t_hdr          wr_data;

    assign req_round = {1'b0, i_req_data[17:2]} + 17'd15;
    assign unit      = r_off[15:4];
    assign u         = unit - UW'(1);

    // clamp the size read during a walk to [1, room below break]
    assign room = r_brk - r_w;
    assign s1   = (r_rd.size == '0) ? SW'(1) : r_rd.size;
    assign s    = (s1 > room) ? room : s1;
    assign lim  = (r_limit > SW'(HEAP_UNITS)) ? SW'(HEAP_UNITS) : r_limit;

    assign cs_diff  = {1'b0, r_cs} - {1'b0, r_csz};
    assign cut_size = o_sts.split ? r_csz : (r_merge ? r_cs : r_raw);
    assign orig_m1  = r_orig - SW'(1);

    always_comb begin
        o_sts            = '0;
        o_sts.req_alloc  = (r_act == ACT_ALLOC) || (r_act == ACT_RESIZE && r_off == '0);
        o_sts.req_free   = (r_act == ACT_FREE);
        o_sts.req_resize = (r_act == ACT_RESIZE) && (r_off != '0);
        o_sts.loc_ok     = (unit != '0) && ({1'b0, u} < r_brk);
        o_sts.bytes_zero = r_bzero;
        o_sts.w_end      = (r_w >= r_brk);
        o_sts.hdr_used   = r_rd.used;
        o_sts.w_is_u     = (r_w == {1'b0, u});
        o_sts.fit        = !r_rd.used && (s >= r_csz);
        o_sts.grow_ok    = (r_brk <= lim) && (r_csz <= lim - r_brk);
        o_sts.split      = !cs_diff[SW] && (cs_diff >= (SW+1)'(2));
        o_sts.orig_fits  = (s >= r_csz);
        o_sts.next_fits  = !r_rd.used && (s >= r_csz - r_orig);
        o_sts.move       = r_move;
        o_sts.out_free   = !r_ovalid || i_rsp_ready;
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_cand;
        wr_data = '0;
        case (i_cmd.wr)
            WR_CAND:  wr_data = '{used: r_keep, size: cut_size};
            WR_SPLIT: begin
                wr_addr = r_cand + r_csz[UW-1:0];
                wr_data = '{used: 1'b0, size: cs_diff[SW-1:0]};
            end
            WR_GROW: begin
                wr_addr = r_brk[UW-1:0];
                wr_data = '{used: 1'b1, size: r_csz};
            end
            WR_GFIN: begin
                wr_addr = u;
                wr_data = '{used: 1'b0, size: r_tot};
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[r_w[UW-1:0]];
    end

    // request fields and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_act    <= i_req_data[1:0];
            r_bzero  <= (i_req_data[17:2] == '0);
            r_off    <= i_req_data[33:18];
            r_csz    <= req_round[16:4] + SW'(1);
            r_status <= ST_OK;
            r_res    <= '0;
            r_csrc   <= '0;
            r_cbytes <= '0;
        end
        case (i_cmd.wsel)
            W_ZERO:  r_w <= '0;
            W_U:     r_w <= {1'b0, u};
            W_STEP:  r_w <= r_w + s;
            default: r_w <= r_w;
        endcase
        if (i_cmd.tot_clr) begin
            r_tot <= '0;
        end else if (i_cmd.tot_add) begin
            r_tot <= r_tot + s;
        end
        if (i_cmd.lat_find) begin
            r_cand  <= r_w[UW-1:0];
            r_raw   <= r_rd.size;
            r_cs    <= s;
            r_keep  <= 1'b1;
            r_merge <= 1'b0;
        end
        if (i_cmd.lat_orig) begin
            r_cand  <= u;
            r_raw   <= r_rd.size;
            r_cs    <= s;
            r_keep  <= r_rd.used;
            r_merge <= 1'b0;
            r_orig  <= s;
        end
        if (i_cmd.lat_merge) begin
            r_cs    <= r_orig + s;
            r_merge <= 1'b1;
        end
        if (i_cmd.wr == WR_GROW) begin
            r_cand <= r_brk[UW-1:0];
        end
        if (i_cmd.lat_result) begin
            r_res <= offset_of(r_cand);
        end
        if (i_cmd.set_copy) begin
            r_csrc   <= offset_of(u);
            r_cbytes <= {orig_m1[UW-1:0], 4'b0000};
        end
        if (i_cmd.set_oom) begin
            r_status <= ST_OOM;
        end
        if (i_cmd.set_zero) begin
            r_status <= ST_ZERO;
        end
        if (i_cmd.out_load) begin
            r_odata <= {6'b0, r_cbytes, r_csrc, r_res, r_status};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk    <= '0;
            r_limit  <= LIMIT_RESET;
            r_move   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.wr == WR_GROW) begin
                r_brk <= r_brk + r_csz;
            end
            if (i_cfg_wr) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.ld_req) begin
                r_move <= 1'b0;
            end else if (i_cmd.set_move) begin
                r_move <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_limit     = r_limit;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp_data  = r_odata;

endmodule
`default_nettype wire

// File: design/first_fit_heap_allocator.sv
// Top level: first-fit heap allocator over 16-byte units with stream and APB ports.
// Each walk visits chunks in order, checking then evaluating each header, around decode,
//   header writes and response; a moving resize walks twice (search, then merge).
// One request in flight, as the sequencer takes a request only in its idle state; the
//   next request is taken once the sequencer returns to idle after the result is
//   loaded, and the response state waits while an older result is still unaccepted.
// Reset (synchronous, active low): break 0, limit 4096, no result pending;
//   the header memory is not cleared and needs no clearing pass.
`default_nettype none
module first_fit_heap_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request: action[1:0], request_bytes[17:2], payload_offset[33:18], zero fill
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    // result: status[1:0], result_offset[17:2], copy_source[33:18],
    //         copy_bytes[49:34], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,
    // configuration: heap_limit_units at byte address 0
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ffha_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    t_state      state;
    logic        cfg_wr;
    logic [12:0] limit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {19'd0, limit};

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_state     (state)
    );

    ffha_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (s_axis_tdata),
        .i_cfg_data  (pwdata[12:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_rsp_data  (m_axis_tdata),
        .i_cfg_wr    (cfg_wr),
        .o_limit     (limit)
    );

    // one request in flight: the port closes right after a request is taken
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // a resize to zero reports no offset and no copy
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == ST_ZERO) |->
        (m_axis_tdata[49:2] == '0))
        else $error("resize to zero carries offsets");

    // out of memory reports no offset and no copy
    a_oom_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == ST_OOM) |->
        (m_axis_tdata[49:2] == '0))
        else $error("out of memory carries offsets");

    // the result register is loaded only in the response state
    a_load_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (state == S_RESP))
        else $error("result loaded outside response state");

endmodule
`default_nettype wire
